/* src/imu_text_record_parser_top_defines.svh */
// Assertion macros for the parser modules; only imu_trp_emit uses them.
`ifndef IMU_TEXT_RECORD_PARSER_TOP_DEFINES_SVH
`define IMU_TEXT_RECORD_PARSER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define IMU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define IMU_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define IMU_ASSERT(lbl, clk, rst_n, prop)
`define IMU_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* src/imu_trp_pkg.sv */
package imu_trp_pkg;

  localparam int unsigned TokDepthDef = 4;
  localparam int unsigned OutDepthDef = 2;

  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [2:0][7:0] HdrText = {8'h75, 8'h6D, 8'h69};
  localparam logic [2:0] HdrLen  = 3'd3;
  localparam logic [2:0] HdrFail = 3'd4;

  localparam logic [3:0] SemiTarget  = 4'd7;
  localparam logic [3:0] ColMax      = 4'd15;
  localparam logic [3:0] ColStamp    = 4'd1;
  localparam logic [3:0] ColFirstVal = 4'd2;
  localparam logic [3:0] ColLastVal  = 4'd7;
  localparam int unsigned NumVals    = 6;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic               line_valid;
    logic [31:0]        time_stamp;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_slot0;
    logic signed [15:0] gyro_slot1;
    logic signed [15:0] gyro_slot2;
  } out_item_t;

  typedef struct packed {
    logic       eol;
    logic       semi;
    logic       ws;
    logic       space;
    logic       minus;
    logic       dig;
    logic [3:0] dval;
    logic [2:0] hdr_hit;
  } token_t;

  typedef struct packed {
    logic [3:0]                col;
    logic [3:0]                semi;
    logic [2:0]                hdr;
    logic                      ok;
    logic [63:0]               mag;
    logic                      neg;
    logic                      ovf;
    logic [31:0]               stamp;
    logic [NumVals-1:0][15:0]  vals;
  } line_t;

  localparam line_t LineInit = '{col: 4'd0, semi: 4'd0, hdr: 3'd0, ok: 1'b1,
                                 mag: 64'd0, neg: 1'b0, ovf: 1'b0,
                                 stamp: 32'd0, vals: '0};

  localparam logic [67:0] LimPos = 68'h0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [67:0] LimNeg = 68'h0_8000_0000_0000_0000;

endpackage

/* src/imu_trp_front.sv */
module imu_trp_front #(
  parameter int unsigned TokDepth = imu_trp_pkg::TokDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  imu_trp_pkg::in_item_t in_item_i,
  output logic                  tok_valid_o,
  output imu_trp_pkg::token_t   tok_o,
  input  logic                  tok_pop_i
);
  import imu_trp_pkg::*;

  localparam int unsigned PtrW = (TokDepth > 1) ? $clog2(TokDepth) : 1;
  localparam int unsigned CntW = $clog2(TokDepth + 1);

  token_t            mem_q [TokDepth];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  token_t            tok_w;
  logic              wr_en;
  logic [7:0]        c;

  always_comb begin
    c               = in_item_i.char_byte;
    tok_w.eol       = in_item_i.end_of_line;
    tok_w.semi      = (c == CharSemi);
    tok_w.space     = (c == CharSpace);
    tok_w.ws        = (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
    tok_w.minus     = (c == CharMinus);
    tok_w.dig       = (c >= CharZero) && (c <= CharNine);
    tok_w.dval      = c[3:0];
    tok_w.hdr_hit   = {c == HdrText[2], c == HdrText[1], c == HdrText[0]};
  end

  assign full        = (cnt_q == CntW'(TokDepth));
  assign wr_en       = push && !full;
  assign tok_valid_o = (cnt_q != '0);
  assign tok_o       = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_en) begin
      wptr_d = (wptr_q == PtrW'(TokDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (tok_pop_i) begin
      rptr_d = (rptr_q == PtrW'(TokDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({wr_en, tok_pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= tok_w;
    end
  end

endmodule

/* src/imu_trp_back.sv */
module imu_trp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tok_valid_i,
  input  imu_trp_pkg::token_t tok_i,
  output logic                tok_pop_o,
  input  logic                fin_ready_i,
  output logic                fin_valid_o,
  output imu_trp_pkg::line_t  fin_o
);
  import imu_trp_pkg::*;

  typedef enum logic [1:0] {
    ChkWs   = 2'd0,
    ChkDig  = 2'd2,
    ChkFail = 2'd3
  } chk_e;

  typedef enum logic [1:0] {
    PrsSp   = 2'd0,
    PrsSign = 2'd1,
    PrsDig  = 2'd2,
    PrsDone = 2'd3
  } prs_e;

  line_t        line_q, line_d;
  chk_e         chk_q, chk_d;
  prs_e         prs_q, prs_d;
  logic [67:0]  acc_sum;
  logic [67:0]  acc_lim;
  logic [31:0]  close_val;
  logic         hdr_match;
  logic         do_acc;
  logic [2:0]   val_idx;

  assign tok_pop_o   = tok_valid_i && (!tok_i.eol || fin_ready_i);
  assign fin_valid_o = tok_pop_o && tok_i.eol;
  assign fin_o       = line_d;

  always_comb begin
    acc_sum   = {1'b0, line_q.mag, 3'b000} + {3'b000, line_q.mag, 1'b0}
              + {64'd0, tok_i.dval};
    acc_lim   = line_q.neg ? LimNeg : LimPos;
    close_val = line_q.ovf ? 32'd0
              : (line_q.neg ? (~line_q.mag[31:0] + 32'd1) : line_q.mag[31:0]);
    val_idx   = 3'(line_q.col - ColFirstVal);
    case (line_q.hdr)
      3'd0:    hdr_match = tok_i.hdr_hit[0];
      3'd1:    hdr_match = tok_i.hdr_hit[1];
      3'd2:    hdr_match = tok_i.hdr_hit[2];
      default: hdr_match = 1'b0;
    endcase

    line_d = line_q;
    chk_d  = chk_q;
    prs_d  = prs_q;
    do_acc = 1'b0;

    if (tok_i.semi) begin
      if (line_q.semi != ColMax) begin
        line_d.semi = line_q.semi + 4'd1;
      end
      if (line_q.col == '0) begin
        if (line_q.hdr != HdrLen) begin
          line_d.ok = 1'b0;
        end
      end else if (line_q.col == ColStamp) begin
        line_d.stamp = close_val;
      end else if (line_q.col <= ColLastVal) begin
        line_d.vals[val_idx] = close_val[15:0];
      end
      if (line_q.col != ColMax) begin
        line_d.col = line_q.col + 4'd1;
      end
      chk_d      = ChkWs;
      prs_d      = PrsSp;
      line_d.mag = '0;
      line_d.neg = 1'b0;
      line_d.ovf = 1'b0;
    end else if (line_q.col == '0) begin
      line_d.hdr = hdr_match ? (line_q.hdr + 3'd1) : HdrFail;
    end else begin
      case (chk_q)
        ChkWs: begin
          if (tok_i.ws) begin
            chk_d = ChkWs;
          end else if (tok_i.minus || tok_i.dig) begin
            chk_d = ChkDig;
          end else begin
            chk_d = ChkFail;
          end
        end
        ChkDig: begin
          if (!tok_i.dig) begin
            chk_d = ChkFail;
          end
        end
        default: chk_d = chk_q;
      endcase
      if (chk_d == ChkFail) begin
        line_d.ok = 1'b0;
      end

      case (prs_q)
        PrsSp: begin
          if (tok_i.space) begin
            prs_d = PrsSp;
          end else if (tok_i.minus) begin
            line_d.neg = 1'b1;
            prs_d      = PrsSign;
          end else if (tok_i.dig) begin
            do_acc = 1'b1;
            prs_d  = PrsDig;
          end else begin
            prs_d = PrsDone;
          end
        end
        PrsSign, PrsDig: begin
          if (tok_i.dig) begin
            do_acc = 1'b1;
            prs_d  = PrsDig;
          end else begin
            prs_d = PrsDone;
          end
        end
        default: prs_d = prs_q;
      endcase

      if (do_acc && !line_q.ovf) begin
        if (acc_sum > acc_lim) begin
          line_d.ovf = 1'b1;
        end else begin
          line_d.mag = acc_sum[63:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= LineInit;
      chk_q  <= ChkWs;
      prs_q  <= PrsSp;
    end else if (tok_pop_o) begin
      if (tok_i.eol) begin
        line_q <= LineInit;
        chk_q  <= ChkWs;
        prs_q  <= PrsSp;
      end else begin
        line_q <= line_d;
        chk_q  <= chk_d;
        prs_q  <= prs_d;
      end
    end
  end

endmodule

/* src/imu_trp_emit.sv */
`include "imu_text_record_parser_top_defines.svh"

module imu_trp_emit #(
  parameter int unsigned OutDepth = imu_trp_pkg::OutDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fin_valid_i,
  input  imu_trp_pkg::line_t     fin_i,
  output logic                   fin_ready_o,
  output logic                   empty,
  input  logic                   pop,
  output imu_trp_pkg::out_item_t out_item_o
);
  import imu_trp_pkg::*;

  localparam int unsigned PtrW = (OutDepth > 1) ? $clog2(OutDepth) : 1;
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  logic              pend_q, pend_d;
  line_t             pend_line_q;
  logic              fire;
  logic              rd_en;
  logic [31:0]       v32;
  logic              line_valid;
  logic [31:0]       stamp_w;
  logic [NumVals-1:0][15:0] vals_w;
  out_item_t         rec;
  out_item_t         mem_q [OutDepth];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign fire        = pend_q && (cnt_q != CntW'(OutDepth));
  assign fin_ready_o = !pend_q || fire;
  assign empty       = (cnt_q == '0);
  assign rd_en       = pop && !empty;
  assign out_item_o  = mem_q[rptr_q];

  always_comb begin
    v32 = pend_line_q.ovf ? 32'd0
        : (pend_line_q.neg ? (~pend_line_q.mag[31:0] + 32'd1) : pend_line_q.mag[31:0]);
    line_valid = pend_line_q.ok && (pend_line_q.semi == SemiTarget)
              && ((pend_line_q.col != '0) || (pend_line_q.hdr == HdrLen));
    stamp_w = (pend_line_q.col == ColStamp) ? v32 : pend_line_q.stamp;
    for (int k = 0; k < NumVals; k++) begin
      vals_w[k] = (pend_line_q.col == 4'(k + 2)) ? v32[15:0] : pend_line_q.vals[k];
    end
    rec = '0;
    if (line_valid) begin
      rec.line_valid = 1'b1;
      rec.time_stamp = stamp_w;
      rec.accel_x    = vals_w[0];
      rec.accel_y    = vals_w[1];
      rec.accel_z    = vals_w[2];
      rec.gyro_slot0 = vals_w[4];
      rec.gyro_slot1 = vals_w[3];
      rec.gyro_slot2 = vals_w[5];
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (fin_valid_i) begin
      pend_d = 1'b1;
    end else if (fire) begin
      pend_d = 1'b0;
    end
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (fire) begin
      wptr_d = (wptr_q == PtrW'(OutDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd_en) begin
      rptr_d = (rptr_q == PtrW'(OutDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({fire, rd_en})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_valid_i) begin
      pend_line_q <= fin_i;
    end
    if (fire) begin
      mem_q[wptr_q] <= rec;
    end
  end

  `IMU_ASSERT(a_invalid_rec_zero, clk_i, rst_ni, (fire && !rec.line_valid) |-> (rec.time_stamp == '0 && rec.accel_x == '0 && rec.accel_y == '0 && rec.accel_z == '0 && rec.gyro_slot0 == '0 && rec.gyro_slot1 == '0 && rec.gyro_slot2 == '0))
  `IMU_ASSERT(a_pend_held, clk_i, rst_ni, (pend_q && !fire) |=> pend_q)
  `IMU_ASSERT_NEVER(a_handoff_overrun, clk_i, rst_ni, fin_valid_i && !fin_ready_o)

endmodule

/* src/imu_text_record_parser_top.sv */
// Path: a line's last beat goes via the token queue and the pending line register into the result queue.
// Throughput: one character beat per cycle while full is low, one record per line; the parser core
// updates its 64-bit accumulator with a single shift-add and compare per character.
// Reset: rst_ni is asynchronous and active low; it empties both queues and
// returns the line state to its start, with no clearing pass.
module imu_text_record_parser_top #(
  parameter int unsigned TokDepth = imu_trp_pkg::TokDepthDef,
  parameter int unsigned OutDepth = imu_trp_pkg::OutDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  imu_trp_pkg::in_item_t  in_item_i,
  output logic                   empty,
  input  logic                   pop,
  output imu_trp_pkg::out_item_t out_item_o
);
  import imu_trp_pkg::*;

  logic   tok_valid;
  logic   tok_pop;
  token_t tok;
  logic   fin_valid;
  logic   fin_ready;
  line_t  fin;

  imu_trp_front #(
    .TokDepth(TokDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .tok_valid_o(tok_valid),
    .tok_o      (tok),
    .tok_pop_i  (tok_pop)
  );

  imu_trp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tok_valid_i(tok_valid),
    .tok_i      (tok),
    .tok_pop_o  (tok_pop),
    .fin_ready_i(fin_ready),
    .fin_valid_o(fin_valid),
    .fin_o      (fin)
  );

  imu_trp_emit #(
    .OutDepth(OutDepth)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fin_valid_i(fin_valid),
    .fin_i      (fin),
    .fin_ready_o(fin_ready),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule
